// File: rtl/rdat_pkg.sv
package rdat_pkg;

  localparam int unsigned SLOTS  = 32;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QDEPTH = 2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1100;
  localparam logic [31:0] LOCAL_SEQ_RESET = 32'd1;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RECV = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_RESEND   = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_NOTHING  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] peer_sequence;
    logic [31:0] peer_ack_number;
    logic [31:0] peer_ack_bits;
    logic [15:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  slot;
    logic [31:0] header_sequence;
    logic [31:0] header_ack_number;
    logic [31:0] header_ack_bits;
    logic [15:0] idle_time;
    logic        last;
  } out_item_t;

  // Classified command held in the queue between front and back.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] peer_sequence;
    logic [31:0] peer_ack_number;
    logic [31:0] peer_ack_bits;
    logic [15:0] elapsed_ticks;
  } op_t;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// File: rtl/rdat_if.sv
interface rdat_in_if;
  import rdat_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdat_out_if;
  import rdat_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rdat_front.sv
module rdat_front
  import rdat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     op_valid_o,
  output op_t      op_o,
  input  logic     op_pop_i
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  op_t              mem_q [QDEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;
  op_t              op_new;

  assign in_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign op_valid_o = (cnt_q != '0);
  assign pop        = op_pop_i && op_valid_o;
  assign op_o       = mem_q[rptr_q];

  always_comb begin
    op_new.cmd             = cmd_e'(in_data_i.command);
    op_new.peer_sequence   = in_data_i.peer_sequence;
    op_new.peer_ack_number = in_data_i.peer_ack_number;
    op_new.peer_ack_bits   = in_data_i.peer_ack_bits;
    op_new.elapsed_ticks   = in_data_i.elapsed_ticks;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rdat_back.sv
module rdat_back
  import rdat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        op_valid_i,
  input  op_t         op_i,
  output logic        op_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e            state_q;
  op_t               cur_q;
  logic [SLOT_W-1:0] idx_q;
  logic [15:0]       timeout_q;
  logic [31:0]       local_seq_q;
  logic [31:0]       rnew_q;
  logic [31:0]       rfield_q;
  logic [15:0]       idle_q;
  logic [SLOTS-1:0]  busy_q;
  logic [31:0]       seq_mem [SLOTS];
  logic [15:0]       age_mem [SLOTS];
  logic              pend_valid_q;
  out_item_t         pend_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              out_free;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [31:0]       rnew_d, rfield_d, diff_up, diff_dn;
  logic [31:0]       s_cur, ack_diff;
  logic [15:0]       age_new;
  logic              w_busy, w_hit, w_expire, w_emit, w_stall;
  out_item_t         w_item;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign op_pop_o    = (state_q == ST_IDLE) && op_valid_i;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Remote sequence tracking.
  always_comb begin
    rnew_d   = rnew_q;
    rfield_d = rfield_q;
    diff_up  = op_i.peer_sequence - rnew_q;
    diff_dn  = rnew_q - op_i.peer_sequence;
    if (op_i.peer_sequence > rnew_q) begin
      rnew_d = op_i.peer_sequence;
      if (diff_up >= 32'd32) begin
        rfield_d = (diff_up == 32'd32) ? 32'h8000_0000 : 32'h0;
      end else begin
        rfield_d = (rfield_q << diff_up[4:0]) | (32'h1 << (diff_up[4:0] - 5'd1));
      end
    end else if (op_i.peer_sequence < rnew_q) begin
      if (diff_dn <= 32'd32) begin
        rfield_d = rfield_q | (32'h1 << 5'(diff_dn - 32'd1));
      end
    end
  end

  // One slot per cycle during the walk while no result is stalled.
  always_comb begin
    w_busy   = busy_q[idx_q];
    s_cur    = seq_mem[idx_q];
    ack_diff = cur_q.peer_ack_number - s_cur;
    age_new  = sat16(age_mem[idx_q], cur_q.elapsed_ticks);
    w_hit    = w_busy && (cur_q.peer_ack_number >= s_cur) &&
               ((ack_diff == 32'd0) ||
                ((ack_diff <= 32'd32) && cur_q.peer_ack_bits[5'(ack_diff - 32'd1)]));
    w_expire = w_busy && (age_new > timeout_q);
    w_emit   = (cur_q.cmd == CMD_RECV) ? w_hit : w_expire;
    w_stall  = w_emit && pend_valid_q && !out_free;
    w_item.kind              = (cur_q.cmd == CMD_RECV) ? KIND_RELEASED : KIND_RESEND;
    w_item.slot              = 5'(idx_q);
    w_item.header_sequence   = (cur_q.cmd == CMD_RECV) ? s_cur : local_seq_q;
    w_item.header_ack_number = rnew_q;
    w_item.header_ack_bits   = rfield_q;
    w_item.idle_time         = idle_q;
    w_item.last              = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && op_valid_i) begin
      cur_q <= op_i;
      if (op_i.cmd == CMD_SEND && free_found) begin
        seq_mem[free_idx] <= local_seq_q;
        age_mem[free_idx] <= '0;
      end
    end else if (state_q == ST_WALK && !w_stall && cur_q.cmd == CMD_TICK && w_busy) begin
      if (w_expire) begin
        seq_mem[idx_q] <= local_seq_q;
        age_mem[idx_q] <= '0;
      end else begin
        age_mem[idx_q] <= age_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      timeout_q    <= TIMEOUT_RESET;
      local_seq_q  <= LOCAL_SEQ_RESET;
      rnew_q       <= '0;
      rfield_q     <= '0;
      idle_q       <= '0;
      busy_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            idx_q <= '0;
            unique case (op_i.cmd)
              CMD_SEND: begin
                pend_valid_q              <= 1'b1;
                pend_q.slot               <= free_found ? 5'(free_idx) : 5'd0;
                pend_q.kind               <= free_found ? KIND_SENT : KIND_FULL;
                pend_q.header_sequence    <= local_seq_q;
                pend_q.header_ack_number  <= rnew_q;
                pend_q.header_ack_bits    <= rfield_q;
                pend_q.idle_time          <= idle_q;
                pend_q.last               <= 1'b0;
                if (free_found) begin
                  busy_q[free_idx] <= 1'b1;
                  local_seq_q      <= local_seq_q + 32'd1;
                end
                state_q <= ST_FIN;
              end
              CMD_RECV: begin
                rnew_q   <= rnew_d;
                rfield_q <= rfield_d;
                idle_q   <= '0;
                state_q  <= ST_WALK;
              end
              CMD_TICK: begin
                idle_q  <= sat16(idle_q, op_i.elapsed_ticks);
                state_q <= ST_WALK;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (!w_stall) begin
            if (w_emit) begin
              // Hold one result back so the final one can carry last.
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_q       <= pend_q;
              end
              pend_valid_q <= 1'b1;
              pend_q       <= w_item;
              if (cur_q.cmd == CMD_RECV) begin
                busy_q[idx_q] <= 1'b0;
              end else begin
                local_seq_q <= local_seq_q + 32'd1;
              end
            end
            if (idx_q == SLOT_W'(SLOTS - 1)) begin
              state_q <= ST_FIN;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (pend_valid_q) begin
              out_q      <= pend_q;
              out_q.last <= 1'b1;
            end else begin
              out_q.kind              <= KIND_NOTHING;
              out_q.slot              <= '0;
              out_q.header_sequence   <= local_seq_q;
              out_q.header_ack_number <= rnew_q;
              out_q.header_ack_bits   <= rfield_q;
              out_q.idle_time         <= idle_q;
              out_q.last              <= 1'b1;
            end
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/reliable_datagram_ack_tracker.sv
// Flow: an accepted item is registered in the front queue and taken by the engine
//   when it is idle; a send or no-op goes through FIN to the output register, a
//   receive or tick first walks all SLOTS slots, one per cycle unless a result stalls.
// The queue keeps accepting items while the engine is busy, until it holds QDEPTH;
//   output stalls hold the engine.
// Reset (rst_ni, async, active low): all slots free, local sequence 1, remote
//   state and idle time zero, resend timeout 1100, queue and output empty.
module reliable_datagram_ack_tracker
  import rdat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  rdat_in_if.sink     in_i,
  rdat_out_if.source  out_o
);

  // Front: accept and classify items into a short queue.
  logic op_valid, op_pop;
  op_t  op;

  rdat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // Back: update sequence state, walk the slot table, drive results through an output
  // register; the front keeps accepting into its queue while a result waits, until it is full.
  rdat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

// File: rtl/rdat_checker.sv
module rdat_checker
  import rdat_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.kind <= KIND_NOTHING)
    else $error("bad result kind");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.kind == KIND_SENT || out_data_i.kind == KIND_FULL ||
                    out_data_i.kind == KIND_NOTHING) |-> out_data_i.last)
    else $error("single result without last");

  a_nothing_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.kind == KIND_NOTHING || out_data_i.kind == KIND_FULL)
    |-> out_data_i.slot == 5'd0)
    else $error("slot set on slotless result");

endmodule

bind reliable_datagram_ack_tracker rdat_checker u_rdat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: tb/ack_tracker_checker.sv
`timescale 1ns / 100ps
module ack_tracker_checker
  import rdat_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic [15:0] cfg_data_i,
  rdat_in_if.sink     in_mon,
  rdat_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  logic [15:0] timeout_q;
  logic [31:0] local_seq;
  logic [31:0] remote_newest;
  logic [31:0] remote_field;
  logic [15:0] idle_cnt;
  logic        busy [SLOTS];
  logic [31:0] slot_seq [SLOTS];
  logic [15:0] slot_age [SLOTS];
  out_item_t   expected_q [$];

  assign pending = expected_q.size();

  function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void push_result(kind_e k, int unsigned sl, logic [31:0] sq);
    out_item_t r;
    r.kind = k;
    r.slot = sl[4:0];
    r.header_sequence = sq;
    r.header_ack_number = remote_newest;
    r.header_ack_bits = remote_field;
    r.idle_time = idle_cnt;
    r.last = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Track the newest partner number and the field of older ones seen.
  function automatic void note_peer(logic [31:0] ps);
    logic [31:0] d;
    if (ps > remote_newest) begin
      d = ps - remote_newest;
      if (d >= 32) remote_field = (d == 32) ? 32'h8000_0000 : 32'h0;
      else remote_field = (remote_field << d) | (32'h1 << (d - 1));
      remote_newest = ps;
    end else if (ps < remote_newest) begin
      d = remote_newest - ps;
      if (d <= 32) remote_field |= 32'h1 << (d - 1);
    end
  endfunction

  function automatic void predict(in_item_t it);
    int n;
    int i;
    logic [31:0] d;
    n = expected_q.size();
    case (it.command)
      CMD_SEND: begin
        for (i = 0; i < SLOTS; i++) if (!busy[i]) break;
        if (i == SLOTS) push_result(KIND_FULL, 0, local_seq);
        else begin
          busy[i] = 1'b1;
          slot_seq[i] = local_seq;
          slot_age[i] = '0;
          push_result(KIND_SENT, i, local_seq);
          local_seq++;
        end
      end
      CMD_RECV: begin
        note_peer(it.peer_sequence);
        idle_cnt = '0;
        for (i = 0; i < SLOTS; i++) begin
          if (busy[i] && it.peer_ack_number >= slot_seq[i]) begin
            d = it.peer_ack_number - slot_seq[i];
            if (d == 0 || (d <= 32 && it.peer_ack_bits[d - 1])) begin
              busy[i] = 1'b0;
              push_result(KIND_RELEASED, i, slot_seq[i]);
            end
          end
        end
      end
      CMD_TICK: begin
        idle_cnt = add_sat(idle_cnt, it.elapsed_ticks);
        for (i = 0; i < SLOTS; i++) begin
          if (busy[i]) begin
            slot_age[i] = add_sat(slot_age[i], it.elapsed_ticks);
            if (slot_age[i] > timeout_q) begin
              slot_seq[i] = local_seq;
              slot_age[i] = '0;
              push_result(KIND_RESEND, i, local_seq);
              local_seq++;
            end
          end
        end
      end
      default: ;
    endcase
    if (expected_q.size() == n) push_result(KIND_NOTHING, 0, local_seq);
    expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void compare(out_item_t got);
    out_item_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (got.kind !== e.kind || got.slot !== e.slot
        || got.header_sequence !== e.header_sequence
        || got.header_ack_number !== e.header_ack_number
        || got.header_ack_bits !== e.header_ack_bits
        || got.idle_time !== e.idle_time || got.last !== e.last) begin
      $display("%0t: mismatch expected %p actual %p", $time, e, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q = TIMEOUT_RESET;
      local_seq = LOCAL_SEQ_RESET;
      remote_newest = '0;
      remote_field = '0;
      idle_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
        busy[i] = 1'b0;
        slot_seq[i] = '0;
        slot_age[i] = '0;
      end
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we_i) timeout_q = cfg_data_i;
      if (in_mon.valid && in_mon.ready) predict(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        compare(out_mon.data);
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import rdat_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          result_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          item_count;

  rdat_in_if  in_ch ();
  rdat_out_if out_ch ();

  reliable_datagram_ack_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ack_tracker_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at random with the current percentage.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", pending);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one item, with a random gap before it, and hold until accepted.
  task automatic put_item(logic [1:0] cmd, logic [31:0] ps, logic [31:0] pa,
                          logic [31:0] pb, logic [15:0] dt);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    it.command = cmd;
    it.peer_sequence = ps;
    it.peer_ack_number = pa;
    it.peer_ack_bits = pb;
    it.elapsed_ticks = dt;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    item_count++;
  endtask

  // Wait for every expected result, then let the block settle before a write.
  task automatic drain_and_write(logic [15:0] value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random stimulus: mostly sends and well-formed acks near recent numbers.
  task automatic random_phase(int count, logic [31:0] seq_hi);
    logic [31:0] base;
    logic [31:0] remote;
    int r;
    remote = $urandom_range(1000);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      base = seq_hi + i;
      if (r < 40) put_item(CMD_SEND, $urandom, $urandom, $urandom, 16'($urandom));
      else if (r < 75) begin
        remote = remote + $urandom_range(40) - 4;
        put_item(CMD_RECV, ($urandom_range(9) == 0) ? $urandom : remote,
                 base - $urandom_range(40), $urandom, 16'($urandom));
      end else if (r < 95)
        put_item(CMD_TICK, $urandom, $urandom, $urandom, 16'($urandom_range(300)));
      else if (r < 98)
        put_item(CMD_TICK, $urandom, $urandom, $urandom, 16'($urandom));
      else put_item(CMD_NONE, $urandom, $urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    idle_cycles = 0;
    item_count = 0;
    send_idle_pct = 20;
    recv_stall_pct = 73;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, table full, duplicate, jumps, old packets, saturation.
    drain_and_write(16'd1);
    for (int i = 0; i < 33; i++) put_item(CMD_SEND, '1, '1, '1, '1);
    put_item(CMD_RECV, 32'd5, 32'd5, 32'h0000_000F, 16'd0);   // ack 5 and 1..4
    put_item(CMD_RECV, 32'd5, 32'd40, 32'hFFFF_FFFF, 16'd0);  // duplicate, wide field
    put_item(CMD_RECV, 32'd37, 32'd0, 32'd0, 16'd0);          // jump of exactly 32
    put_item(CMD_RECV, 32'd100, 32'd0, 32'd0, 16'd0);         // large jump
    put_item(CMD_RECV, 32'd68, 32'd0, 32'd0, 16'd0);          // 32 below
    put_item(CMD_RECV, 32'd10, 32'd0, 32'd0, 16'd0);          // too old
    put_item(CMD_RECV, 32'hFFFF_FFFF, '1, '1, 16'd0);
    put_item(CMD_TICK, '0, '0, '0, 16'd1);
    put_item(CMD_TICK, '0, '0, '0, 16'd2);
    put_item(CMD_TICK, '0, '0, '0, 16'hFFFF);
    put_item(CMD_TICK, '0, '0, '0, 16'hFFFF);
    put_item(CMD_NONE, '1, '1, '1, '1);
    put_item(CMD_NONE, '0, '0, '0, '0);
    drain_and_write(16'hFFFF);                                // never fires
    put_item(CMD_TICK, '0, '0, '0, 16'hFFFF);
    put_item(CMD_RECV, '0, '1, '1, '1);
    put_item(CMD_RECV, '0, '0, '0, '0);

    drain_and_write(16'd1100);
    random_phase(120, 32'd100);

    send_idle_pct = 73;
    recv_stall_pct = 20;
    drain_and_write(16'd150);
    random_phase(110, 32'd150);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_and_write(16'd40);
    random_phase(120, 32'd250);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    $display("covered %0d items and %0d results over send, receive, tick and no-op",
             item_count, result_count);
    $display("with timeouts 1, 65535, 1100, 150, 40 and three idling patterns");
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
